// File: src/cts_pkg.sv
// ---------------------------------------------------------------------------
// cts_pkg: shared types and codes of the calendar time set controller
// Field types, edit state codes, key codes, display codes and the
// item, state and result records passed between the modules.
// ---------------------------------------------------------------------------
`default_nettype none

package cts_pkg;

  // field types
  typedef logic [2:0] action_t;
  typedef logic [6:0] year_t;
  typedef logic [3:0] month_t;
  typedef logic [4:0] day_t;
  typedef logic [4:0] hour_t;
  typedef logic [5:0] minute_t;
  typedef logic [5:0] second_t;
  typedef logic [2:0] mode_t;
  typedef logic [1:0] disp_t;

  // edit state codes
  localparam mode_t ST_IDLE   = 3'd0;
  localparam mode_t ST_YEAR   = 3'd1;
  localparam mode_t ST_MONTH  = 3'd2;
  localparam mode_t ST_DAY    = 3'd3;
  localparam mode_t ST_HOUR   = 3'd4;
  localparam mode_t ST_MINUTE = 3'd5;
  localparam mode_t ST_SECOND = 3'd6;

  // key codes
  localparam action_t KEY_NONE = 3'd0;
  localparam action_t KEY_A    = 3'd1;
  localparam action_t KEY_B    = 3'd2;
  localparam action_t KEY_C    = 3'd3;
  localparam action_t KEY_D    = 3'd4;

  // display refresh codes
  localparam disp_t DISP_NONE = 2'd0;
  localparam disp_t DISP_LIVE = 2'd1;
  localparam disp_t DISP_EDIT = 2'd2;

  // one input item
  typedef struct packed {
    action_t action;
    year_t   live_year;
    month_t  live_month;
    day_t    live_day;
    hour_t   live_hour;
    minute_t live_minute;
    second_t live_second;
    logic    not_leap_year;
  } in_item_t;

  // controller state
  typedef struct packed {
    logic    phase;
    mode_t   mode;
    year_t   year;
    month_t  month;
    day_t    day;
    hour_t   hour;
    minute_t minute;
    second_t second;
  } state_t;

  // one result item
  typedef struct packed {
    mode_t   mode;
    year_t   shown_year;
    month_t  shown_month;
    day_t    shown_day;
    hour_t   shown_hour;
    minute_t shown_minute;
    second_t shown_second;
    disp_t   display_update;
    logic    write_rtc;
  } out_item_t;

endpackage

`default_nettype wire

// File: src/cts_in_if.sv
// ---------------------------------------------------------------------------
// cts_in_if: key and live time channel
// Valid/ready channel carrying one key tick and the live RTC time.
// ---------------------------------------------------------------------------
`default_nettype none

interface cts_in_if;
  logic             valid;
  logic             ready;
  cts_pkg::action_t action;
  cts_pkg::year_t   live_year;
  cts_pkg::month_t  live_month;
  cts_pkg::day_t    live_day;
  cts_pkg::hour_t   live_hour;
  cts_pkg::minute_t live_minute;
  cts_pkg::second_t live_second;
  logic             not_leap_year;

  modport source (
    output valid, action, live_year, live_month, live_day, live_hour,
           live_minute, live_second, not_leap_year,
    input  ready
  );

  modport sink (
    input  valid, action, live_year, live_month, live_day, live_hour,
           live_minute, live_second, not_leap_year,
    output ready
  );
endinterface

`default_nettype wire

// File: src/cts_out_if.sv
// ---------------------------------------------------------------------------
// cts_out_if: edit status channel
// Valid/ready channel carrying the edit state, edited time and requests.
// ---------------------------------------------------------------------------
`default_nettype none

interface cts_out_if;
  logic             valid;
  logic             ready;
  cts_pkg::mode_t   mode;
  cts_pkg::year_t   shown_year;
  cts_pkg::month_t  shown_month;
  cts_pkg::day_t    shown_day;
  cts_pkg::hour_t   shown_hour;
  cts_pkg::minute_t shown_minute;
  cts_pkg::second_t shown_second;
  cts_pkg::disp_t   display_update;
  logic             write_rtc;

  modport source (
    output valid, mode, shown_year, shown_month, shown_day, shown_hour,
           shown_minute, shown_second, display_update, write_rtc,
    input  ready
  );

  modport sink (
    input  valid, mode, shown_year, shown_month, shown_day, shown_hour,
           shown_minute, shown_second, display_update, write_rtc,
    output ready
  );
endinterface

`default_nettype wire

// File: src/cts_step.sv
// ---------------------------------------------------------------------------
// cts_step: next-state logic of the time set controller
// Works out the next edit state, edited fields and requests for one tick.
// ---------------------------------------------------------------------------
`default_nettype none

module cts_step (
  input  wire cts_pkg::state_t   state_i,
  input  wire cts_pkg::in_item_t item_i,
  output cts_pkg::state_t        state_o,
  output cts_pkg::out_item_t     result_o
);
  import cts_pkg::*;

  // wrap to lo at or above hi
  function automatic logic [6:0] wrap_up(input logic [6:0] v, input logic [6:0] lo,
                                         input logic [6:0] hi);
    return (v >= hi) ? lo : v + 7'd1;
  endfunction

  // wrap to hi at or below lo, or when out of range
  function automatic logic [6:0] wrap_down(input logic [6:0] v, input logic [6:0] lo,
                                           input logic [6:0] hi);
    return (v <= lo || v > hi) ? hi : v - 7'd1;
  endfunction

  function automatic logic short_month(input month_t m);
    return m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11;
  endfunction

  function automatic day_t month_len(input month_t m);
    day_t len;
    if (m == 4'd2) len = 5'd29;
    else if (short_month(m)) len = 5'd30;
    else len = 5'd31;
    return len;
  endfunction

  state_t  nxt;
  disp_t   disp;
  logic    wr;
  logic    up;
  logic    time_ok;
  month_t  new_month;
  day_t    lim;

  // validation of the edited time on apply
  always_comb begin
    time_ok = 1'b1;
    if (state_i.hour >= 5'd24 || state_i.minute >= 6'd60 || state_i.second >= 6'd60)
      time_ok = 1'b0;
    else if (state_i.month >= 4'd13)
      time_ok = 1'b0;
    else if (short_month(state_i.month))
      time_ok = state_i.day < 5'd31;
    else if (state_i.month == 4'd2)
      time_ok = item_i.not_leap_year ? (state_i.day < 5'd29) : (state_i.day < 5'd30);
  end

  // month step and day limit
  assign up = (item_i.action == KEY_B);
  assign new_month = up ? month_t'(wrap_up({3'd0, state_i.month}, 7'd1, 7'd12))
                        : month_t'(wrap_down({3'd0, state_i.month}, 7'd1, 7'd12));
  assign lim = month_len(state_i.month);

  // tick handling
  always_comb begin
    nxt       = state_i;
    nxt.phase = ~state_i.phase;
    disp      = DISP_NONE;
    wr        = 1'b0;
    if (!state_i.phase) begin
      if (state_i.mode == ST_IDLE || state_i.mode > ST_SECOND) begin
        if (item_i.action == KEY_A) begin
          nxt.year   = item_i.live_year;
          nxt.month  = item_i.live_month;
          nxt.day    = item_i.live_day;
          nxt.hour   = item_i.live_hour;
          nxt.minute = item_i.live_minute;
          nxt.second = item_i.live_second;
          nxt.mode   = ST_YEAR;
          disp       = DISP_EDIT;
        end
      end else if (item_i.action == KEY_D) begin
        nxt.year   = item_i.live_year;
        nxt.month  = item_i.live_month;
        nxt.day    = item_i.live_day;
        nxt.hour   = item_i.live_hour;
        nxt.minute = item_i.live_minute;
        nxt.second = item_i.live_second;
        nxt.mode   = ST_IDLE;
        disp       = DISP_LIVE;
      end else if (item_i.action == KEY_A) begin
        if (state_i.mode == ST_SECOND) begin
          wr       = time_ok;
          nxt.mode = ST_IDLE;
          disp     = DISP_LIVE;
        end else begin
          nxt.mode = state_i.mode + 3'd1;
        end
      end else if (item_i.action == KEY_B || item_i.action == KEY_C) begin
        disp = DISP_EDIT;
        unique case (state_i.mode)
          ST_YEAR: begin
            nxt.year = up ? wrap_up(state_i.year, 7'd0, 7'd99)
                          : wrap_down(state_i.year, 7'd0, 7'd99);
          end
          ST_MONTH: begin
            nxt.month = new_month;
            if (state_i.day > month_len(new_month)) nxt.day = 5'd1;
          end
          ST_DAY: begin
            nxt.day = up ? day_t'(wrap_up({2'd0, state_i.day}, 7'd1, {2'd0, lim}))
                         : day_t'(wrap_down({2'd0, state_i.day}, 7'd1, {2'd0, lim}));
          end
          ST_HOUR: begin
            nxt.hour = up ? hour_t'(wrap_up({2'd0, state_i.hour}, 7'd0, 7'd23))
                          : hour_t'(wrap_down({2'd0, state_i.hour}, 7'd0, 7'd23));
          end
          ST_MINUTE: begin
            nxt.minute = up ? minute_t'(wrap_up({1'b0, state_i.minute}, 7'd0, 7'd59))
                            : minute_t'(wrap_down({1'b0, state_i.minute}, 7'd0, 7'd59));
          end
          default: begin
            nxt.second = up ? second_t'(wrap_up({1'b0, state_i.second}, 7'd0, 7'd59))
                            : second_t'(wrap_down({1'b0, state_i.second}, 7'd0, 7'd59));
          end
        endcase
      end
    end
  end

  // result record
  always_comb begin
    state_o                 = nxt;
    result_o.mode           = nxt.mode;
    result_o.shown_year     = nxt.year;
    result_o.shown_month    = nxt.month;
    result_o.shown_day      = nxt.day;
    result_o.shown_hour     = nxt.hour;
    result_o.shown_minute   = nxt.minute;
    result_o.shown_second   = nxt.second;
    result_o.display_update = disp;
    result_o.write_rtc      = wr;
  end

endmodule

`default_nettype wire

// File: src/calendar_time_set_fsm.sv
// ---------------------------------------------------------------------------
// calendar_time_set_fsm: keypad date/time setting controller
// Input register, next-state logic and result register with edit state.
// ---------------------------------------------------------------------------
// One item is taken per clock unless the input is stalled, and each item gives
// one result: the item lands in the input register, then the next-state logic
// updates the phase, edit state and edited fields and loads the result
// register in the same cycle. Only every second item (the one that sets the
// phase bit) acts on the keys. Both sides are decoupled by their registers,
// so a waiting result stalls the input only once both registers are full.
`default_nettype none

module calendar_time_set_fsm (
  input  wire        clk_i,
  input  wire        rst_ni,
  cts_in_if.sink     in_i,
  cts_out_if.source  out_o
);
  import cts_pkg::*;

  in_item_t  item_q;
  logic      item_vld_q;
  state_t    state_q, state_d;
  out_item_t res_q, res_d;
  logic      res_vld_q;
  logic      adv;

  // advance the item into the result register when there is room
  assign adv         = item_vld_q && (!res_vld_q || out_o.ready);
  assign in_i.ready  = !item_vld_q || adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      item_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.action        <= in_i.action;
      item_q.live_year     <= in_i.live_year;
      item_q.live_month    <= in_i.live_month;
      item_q.live_day      <= in_i.live_day;
      item_q.live_hour     <= in_i.live_hour;
      item_q.live_minute   <= in_i.live_minute;
      item_q.live_second   <= in_i.live_second;
      item_q.not_leap_year <= in_i.not_leap_year;
    end
  end

  // next-state logic
  cts_step u_step (
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // edit state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase  <= 1'b0;
      state_q.mode   <= ST_IDLE;
      state_q.year   <= 7'd0;
      state_q.month  <= 4'd1;
      state_q.day    <= 5'd1;
      state_q.hour   <= 5'd0;
      state_q.minute <= 6'd0;
      state_q.second <= 6'd0;
    end else if (adv) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (adv) begin
      res_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  // output transfer
  assign out_o.valid          = res_vld_q;
  assign out_o.mode           = res_q.mode;
  assign out_o.shown_year     = res_q.shown_year;
  assign out_o.shown_month    = res_q.shown_month;
  assign out_o.shown_day      = res_q.shown_day;
  assign out_o.shown_hour     = res_q.shown_hour;
  assign out_o.shown_minute   = res_q.shown_minute;
  assign out_o.shown_second   = res_q.shown_second;
  assign out_o.display_update = res_q.display_update;
  assign out_o.write_rtc      = res_q.write_rtc;

endmodule

`default_nettype wire

// File: tb/sv/cts_result_check.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cts_result_check: result checker for the calendar time set controller
// Watches both channels, keeps a shadow copy of the phase bit, edit state
// and edited fields, works out the status each key tick should give and
// compares every status transfer against the oldest outstanding one.
// ---------------------------------------------------------------------------

module cts_result_check (
  input  logic clk_i,
  input  logic rst_ni,
  cts_in_if    key_mon,
  cts_out_if   status_mon,
  output int   fail_count_o,
  output int   pending_o
);
  import cts_pkg::*;

  localparam int MAX_PRINTS = 40;

  state_t    ed;
  out_item_t status_due_q[$];
  int        errors = 0;

  assign fail_count_o = errors;

  function automatic logic is_short_month(month_t m);
    return m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11;
  endfunction

  // february is always allowed 29 days while editing
  function automatic int last_day(month_t m);
    if (m == 4'd2) return 29;
    if (is_short_month(m)) return 30;
    return 31;
  endfunction

  function automatic int wrap_up(int v, int lo, int hi);
    return (v >= hi) ? lo : v + 1;
  endfunction

  // anything out of range on the way down lands on the maximum
  function automatic int wrap_down(int v, int lo, int hi);
    return (v <= lo || v > hi) ? hi : v - 1;
  endfunction

  task automatic report(string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("%0t check: %s", $time, msg);
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic copy_live(in_item_t it);
    ed.year   = it.live_year;
    ed.month  = it.live_month;
    ed.day    = it.live_day;
    ed.hour   = it.live_hour;
    ed.minute = it.live_minute;
    ed.second = it.live_second;
  endtask

  // one key tick: update the shadow editor and queue the status it gives
  task automatic advance_editor(in_item_t it);
    out_item_t r;
    logic      up;
    r = '0;
    r.display_update = DISP_NONE;
    r.write_rtc = 1'b0;
    ed.phase = ~ed.phase;
    if (ed.phase) begin
      if (ed.mode == ST_IDLE || ed.mode > ST_SECOND) begin
        if (it.action == KEY_A) begin
          copy_live(it);
          ed.mode = ST_YEAR;
          r.display_update = DISP_EDIT;
        end
      end else if (it.action == KEY_D) begin
        copy_live(it);
        ed.mode = ST_IDLE;
        r.display_update = DISP_LIVE;
      end else if (it.action == KEY_A) begin
        if (ed.mode == ST_SECOND) begin
          // validate before asking for the rtc write; year and zero fields pass
          if (ed.hour >= 24 || ed.minute >= 60 || ed.second >= 60 || ed.month >= 13)
            r.write_rtc = 1'b0;
          else if (is_short_month(ed.month))
            r.write_rtc = (ed.day < 31);
          else if (ed.month == 4'd2)
            r.write_rtc = it.not_leap_year ? (ed.day < 29) : (ed.day < 30);
          else
            r.write_rtc = 1'b1;
          ed.mode = ST_IDLE;
          r.display_update = DISP_LIVE;
        end else begin
          ed.mode = mode_t'(ed.mode + 3'd1);
        end
      end else if (it.action == KEY_B || it.action == KEY_C) begin
        up = (it.action == KEY_B);
        case (ed.mode)
          ST_YEAR: ed.year = year_t'(up ? wrap_up(ed.year, 0, 99) : wrap_down(ed.year, 0, 99));
          ST_MONTH: begin
            ed.month = month_t'(up ? wrap_up(ed.month, 1, 12) : wrap_down(ed.month, 1, 12));
            if (ed.day > last_day(ed.month)) ed.day = 5'd1;
          end
          ST_DAY: begin
            ed.day = day_t'(up ? wrap_up(ed.day, 1, last_day(ed.month))
                               : wrap_down(ed.day, 1, last_day(ed.month)));
          end
          ST_HOUR: ed.hour = hour_t'(up ? wrap_up(ed.hour, 0, 23) : wrap_down(ed.hour, 0, 23));
          ST_MINUTE: begin
            ed.minute = minute_t'(up ? wrap_up(ed.minute, 0, 59) : wrap_down(ed.minute, 0, 59));
          end
          default: begin
            ed.second = second_t'(up ? wrap_up(ed.second, 0, 59) : wrap_down(ed.second, 0, 59));
          end
        endcase
        r.display_update = DISP_EDIT;
      end
    end
    r.mode         = ed.mode;
    r.shown_year   = ed.year;
    r.shown_month  = ed.month;
    r.shown_day    = ed.day;
    r.shown_hour   = ed.hour;
    r.shown_minute = ed.minute;
    r.shown_second = ed.second;
    status_due_q.push_back(r);
  endtask

  // watch key and status transfers
  always @(posedge clk_i or negedge rst_ni) begin : watch
    in_item_t  it;
    out_item_t want;
    if (!rst_ni) begin
      ed = '0;
      ed.mode = ST_IDLE;
      ed.month = 4'd1;
      ed.day = 5'd1;
      status_due_q.delete();
      pending_o <= 0;
    end else begin
      if (key_mon.valid && key_mon.ready) begin
        it.action        = key_mon.action;
        it.live_year     = key_mon.live_year;
        it.live_month    = key_mon.live_month;
        it.live_day      = key_mon.live_day;
        it.live_hour     = key_mon.live_hour;
        it.live_minute   = key_mon.live_minute;
        it.live_second   = key_mon.live_second;
        it.not_leap_year = key_mon.not_leap_year;
        advance_editor(it);
      end
      if (status_mon.valid && status_mon.ready) begin
        if (status_due_q.size() == 0) begin
          report("status transfer with nothing outstanding");
        end else begin
          want = status_due_q.pop_front();
          check_field("mode", status_mon.mode, want.mode);
          check_field("shown_year", status_mon.shown_year, want.shown_year);
          check_field("shown_month", status_mon.shown_month, want.shown_month);
          check_field("shown_day", status_mon.shown_day, want.shown_day);
          check_field("shown_hour", status_mon.shown_hour, want.shown_hour);
          check_field("shown_minute", status_mon.shown_minute, want.shown_minute);
          check_field("shown_second", status_mon.shown_second, want.shown_second);
          check_field("display_update", status_mon.display_update, want.display_update);
          check_field("write_rtc", status_mon.write_rtc, want.write_rtc);
        end
      end
      pending_o <= status_due_q.size();
    end
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: top level for the calendar time set controller
// Drives key ticks with live time in bursts, mostly as whole edit sessions
// placed on the acting ticks, stalls the status side on shifting patterns
// and gives the verdict from the checker's error count.
// ---------------------------------------------------------------------------

module testbench;
  import cts_pkg::*;

  localparam int      ITEM_TARGET = 650;
  localparam int      CYCLE_LIMIT = 200000;
  localparam action_t KEY_UNUSED  = 3'd7;

  logic clk_i;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending_count;
  int   n_sent = 0;
  int   burst_left = 0;
  int   cycle_count = 0;

  cts_in_if  key_if ();
  cts_out_if status_if ();

  calendar_time_set_fsm dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (key_if),
    .out_o  (status_if)
  );

  cts_result_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_mon      (key_if),
    .status_mon   (status_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // mostly in-range live time, with the odd field taking any bit pattern
  function automatic in_item_t random_live();
    in_item_t it;
    it.action = action_t'($urandom_range(0, 7));
    it.live_year = ($urandom_range(0, 4) == 0) ? year_t'($urandom)
                                               : year_t'($urandom_range(0, 99));
    it.live_month = ($urandom_range(0, 4) == 0) ? month_t'($urandom) :
                    ($urandom_range(0, 2) == 0) ? month_t'(2) :
                                                  month_t'($urandom_range(1, 12));
    it.live_day = ($urandom_range(0, 4) == 0) ? day_t'($urandom) :
                  ($urandom_range(0, 2) == 0) ? day_t'($urandom_range(28, 31)) :
                                                day_t'($urandom_range(1, 31));
    it.live_hour = ($urandom_range(0, 4) == 0) ? hour_t'($urandom)
                                               : hour_t'($urandom_range(0, 23));
    it.live_minute = ($urandom_range(0, 4) == 0) ? minute_t'($urandom)
                                                 : minute_t'($urandom_range(0, 59));
    it.live_second = ($urandom_range(0, 4) == 0) ? second_t'($urandom)
                                                 : second_t'($urandom_range(0, 59));
    it.not_leap_year = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // one key transfer, with a random gap opening each new burst
  task automatic send_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        key_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    key_if.valid         <= 1'b1;
    key_if.action        <= it.action;
    key_if.live_year     <= it.live_year;
    key_if.live_month    <= it.live_month;
    key_if.live_day      <= it.live_day;
    key_if.live_hour     <= it.live_hour;
    key_if.live_minute   <= it.live_minute;
    key_if.live_second   <= it.live_second;
    key_if.not_leap_year <= it.not_leap_year;
    @(posedge clk_i);
    while (!key_if.ready) @(posedge clk_i);
    burst_left--;
    n_sent++;
  endtask

  // land a key on an acting tick; a random tick fills the ignored slot
  task automatic press(action_t key, in_item_t lv);
    if (n_sent % 2 == 1) send_item(random_live());
    lv.action = key;
    send_item(lv);
  endtask

  // enter, nudge each field, step on; now and then cancel midway
  task automatic edit_session();
    int nsteps;
    press(KEY_A, random_live());
    for (int f = 0; f < 6; f++) begin
      nsteps = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 4);
      repeat (nsteps) press(($urandom_range(0, 1) == 1) ? KEY_B : KEY_C, random_live());
      if ($urandom_range(0, 7) == 0) press(KEY_NONE, random_live());
      if ($urandom_range(0, 15) == 0) begin
        press(KEY_D, random_live());
        return;
      end
      press(KEY_A, random_live());
    end
  endtask

  // status side stalls
  initial begin : stall_gen
    int stall_mode;
    int tick;
    stall_mode = 0;
    tick = 0;
    status_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (tick % 64 == 0) stall_mode = $urandom_range(0, 3);
      tick++;
      case (stall_mode)
        0:       status_if.ready <= 1'b1;
        1:       status_if.ready <= ($urandom_range(0, 1) == 1);
        2:       status_if.ready <= ($urandom_range(0, 3) == 0);
        default: status_if.ready <= (tick % 3 == 0);
      endcase
    end
  end

  // stimulus and verdict
  initial begin : stim
    in_item_t lv;
    in_item_t wild;
    key_if.valid         <= 1'b0;
    key_if.action        <= KEY_NONE;
    key_if.live_year     <= '0;
    key_if.live_month    <= '0;
    key_if.live_day      <= '0;
    key_if.live_hour     <= '0;
    key_if.live_minute   <= '0;
    key_if.live_second   <= '0;
    key_if.not_leap_year <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // field extremes, wraps, month clamp and a non-leap feb 29 apply
    lv = '{action: KEY_NONE, live_year: 7'd99, live_month: 4'd3, live_day: 5'd31,
           live_hour: 5'd23, live_minute: 6'd0, live_second: 6'd59, not_leap_year: 1'b1};
    press(KEY_B, lv);
    press(KEY_A, lv);
    press(KEY_B, lv);
    press(KEY_C, lv);
    press(KEY_UNUSED, lv);
    press(KEY_A, lv);
    press(KEY_C, lv);
    press(KEY_A, lv);
    press(KEY_C, lv);
    press(KEY_A, lv);
    press(KEY_B, lv);
    press(KEY_A, lv);
    press(KEY_C, lv);
    press(KEY_A, lv);
    press(KEY_B, lv);
    press(KEY_A, lv);

    // entry and cancel with every live field at its top bit pattern
    wild = '{action: KEY_NONE, live_year: '1, live_month: '1, live_day: '1,
             live_hour: '1, live_minute: '1, live_second: '1, not_leap_year: 1'b0};
    press(KEY_A, wild);
    press(KEY_D, lv);

    // random sessions with some loose ticks in between
    while (n_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 8)) send_item(random_live());
      else
        edit_session();
    end

    key_if.valid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// File: filelist.f
src/cts_pkg.sv
src/cts_in_if.sv
src/cts_out_if.sv
src/cts_step.sv
src/calendar_time_set_fsm.sv
tb/sv/cts_result_check.sv
tb/sv/testbench.sv
